>>> src/encoder_chain_stuck_detector_unit_assert.svh
// ---------------------------------------------------------------------------
// Encoder chain stuck detector assertion macros
// Shared property wrappers for the concurrent checks in the top level.
// ---------------------------------------------------------------------------
`ifndef ENCODER_CHAIN_STUCK_DETECTOR_UNIT_ASSERT_SVH
`define ENCODER_CHAIN_STUCK_DETECTOR_UNIT_ASSERT_SVH

// Implication check on clk, switched off while reset is asserted.
`define ECSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define ECSD_ASSERT_NEVER(label, cond, msg) \
    `ECSD_ASSERT(label, !(cond), msg)

`endif

>>> src/ecsd_pkg.sv
// ---------------------------------------------------------------------------
// Encoder chain stuck detector package
// Sizes, constants and the result type shared by the detector modules.
// ---------------------------------------------------------------------------
package ecsd_pkg;

    localparam int ENCODER_COUNT = 3;
    localparam int ENC_W         = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;
    localparam int WORD_W        = 16;
    localparam int POS_W         = 14;
    localparam int IDX_W         = 4;
    localparam int COUNT_W       = 8;
    localparam int MASK_BITS     = 3;

    localparam logic [ENC_W-1:0]   LAST_SLOT       = ENC_W'(ENCODER_COUNT - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(100);

    typedef struct packed {
        logic [IDX_W-1:0]     encoder_index;
        logic [POS_W-1:0]     position;
        logic                 frame_done;
        logic [MASK_BITS-1:0] stuck_mask;
        logic                 all_stuck;
    } ecsd_result_t;

endpackage

>>> src/encoder_chain_stuck_detector_unit.sv
// ---------------------------------------------------------------------------
// Encoder chain stuck detector
// Tracks the angle words of an encoder daisy chain and flags encoders and
// whole frames that keep repeating the same reading.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Handshake        | Beat
//  ---------+-----------+------------------+--------------------------------
//  in       | input     | in_valid/stall   | spi_word
//  out      | output    | out_valid/stall  | encoder_index, position, ...
//  cfg      | input     | cfg_valid/ready  | cfg_data (stuck threshold)
//
// Each word passes through the input register and then the result
// register; one beat per cycle is sustained while the output is not stalled.
// The tracker state is updated as a word moves into the result register.
// A waiting result does not block a new input beat; input stalls only when
// both the input register and a stalled result register are full.
// Reset clears the chain state and loads the threshold with 100.
// ---------------------------------------------------------------------------
`include "encoder_chain_stuck_detector_unit_assert.svh"

module encoder_chain_stuck_detector_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ecsd_pkg::WORD_W-1:0]        spi_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ecsd_pkg::IDX_W-1:0]         encoder_index,
    output logic [ecsd_pkg::POS_W-1:0]         position,
    output logic                               frame_done,
    output logic [ecsd_pkg::MASK_BITS-1:0]     stuck_mask,
    output logic                               all_stuck,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ecsd_pkg::COUNT_W-1:0]       cfg_data
);
    import ecsd_pkg::*;

    logic               s1_valid_reg, s1_valid_next;
    logic [WORD_W-1:0]  s1_word_reg;
    logic               out_valid_reg, out_valid_next;
    ecsd_result_t       out_reg;
    ecsd_result_t       result;
    logic [COUNT_W-1:0] threshold_reg;
    logic               advance;
    logic               in_accept;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    ecsd_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .word      (s1_word_reg),
        .threshold (threshold_reg),
        .result    (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                threshold_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_word_reg <= spi_word;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign encoder_index = out_reg.encoder_index;
    assign position      = out_reg.position;
    assign frame_done    = out_reg.frame_done;
    assign stuck_mask    = out_reg.stuck_mask;
    assign all_stuck     = out_reg.all_stuck;

    // The last word of a frame always belongs to encoder zero.
    `ECSD_ASSERT(a_done_on_enc0, (out_valid && frame_done) |-> encoder_index == '0, "done off encoder 0")
    // A blocked result register must not be overwritten.
    `ECSD_ASSERT_NEVER(a_no_overwrite, out_valid_reg && out_stall && advance, "result overwritten")
    // Input only stalls while a word is held in the input register.
    `ECSD_ASSERT(a_stall_held, in_stall |-> s1_valid_reg, "input stalled with empty input register")
    // The threshold only changes after a configuration write.
    `ECSD_ASSERT(a_thr_write, !$stable(threshold_reg) |-> $past(cfg_valid), "stray threshold change")

endmodule

>>> src/ecsd_tracker.sv
// ---------------------------------------------------------------------------
// Encoder chain stuck detector tracker
// Per-encoder position and repeat state, frame repeat counter and stuck
// flags; one word is folded into the state on each step.
// ---------------------------------------------------------------------------
module ecsd_tracker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [ecsd_pkg::WORD_W-1:0]      word,
    input  logic [ecsd_pkg::COUNT_W-1:0]     threshold,
    output ecsd_pkg::ecsd_result_t           result
);
    import ecsd_pkg::*;

    logic [ENC_W-1:0]   slot_reg, slot_next;
    logic [POS_W-1:0]   last_pos_reg [ENCODER_COUNT];
    logic [POS_W-1:0]   last_pos_next [ENCODER_COUNT];
    logic [COUNT_W-1:0] rep_cnt_reg [ENCODER_COUNT];
    logic [COUNT_W-1:0] rep_cnt_next [ENCODER_COUNT];
    logic               unchanged_reg, unchanged_next;
    logic [COUNT_W-1:0] frame_cnt_reg, frame_cnt_next;
    logic [MASK_BITS-1:0] stuck_reg, stuck_next;
    logic               all_reg, all_next;

    logic [ENC_W-1:0]   enc;
    logic [POS_W-1:0]   pos;
    logic               match;
    logic               done;
    logic               unchanged_base;

    assign pos   = word[POS_W-1:0];
    assign enc   = LAST_SLOT - slot_reg;
    assign match = (pos == last_pos_reg[enc]);
    assign done  = (slot_reg == LAST_SLOT);

    // A frame starts out unchanged; any mismatch in it clears the mark.
    assign unchanged_base = (slot_reg == '0) ? 1'b1 : unchanged_reg;

    always_comb
    begin
        slot_next      = done ? '0 : slot_reg + ENC_W'(1);
        unchanged_next = match ? unchanged_base : 1'b0;

        for (int k = 0; k < ENCODER_COUNT; k++)
        begin
            last_pos_next[k] = last_pos_reg[k];
            rep_cnt_next[k]  = rep_cnt_reg[k];
            if (ENC_W'(k) == enc)
            begin
                last_pos_next[k] = pos;
                if (!match)
                begin
                    rep_cnt_next[k] = '0;
                end
                else if (rep_cnt_reg[k] != COUNT_MAX)
                begin
                    rep_cnt_next[k] = rep_cnt_reg[k] + COUNT_W'(1);
                end
            end
        end

        frame_cnt_next = frame_cnt_reg;
        stuck_next     = stuck_reg;
        all_next       = all_reg;
        if (done)
        begin
            if (!unchanged_next)
            begin
                frame_cnt_next = '0;
            end
            else if (frame_cnt_reg < threshold)
            begin
                frame_cnt_next = frame_cnt_reg + COUNT_W'(1);
            end
            all_next = (frame_cnt_next >= threshold);
            for (int k = 0; k < MASK_BITS; k++)
            begin
                if (k < ENCODER_COUNT)
                begin
                    stuck_next[k] = (rep_cnt_next[k] >= threshold);
                end
                else
                begin
                    stuck_next[k] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            unchanged_reg <= 1'b1;
            frame_cnt_reg <= '0;
            stuck_reg     <= '0;
            all_reg       <= 1'b0;
            for (int k = 0; k < ENCODER_COUNT; k++)
            begin
                last_pos_reg[k] <= '0;
                rep_cnt_reg[k]  <= '0;
            end
        end
        else if (step)
        begin
            slot_reg      <= slot_next;
            unchanged_reg <= unchanged_next;
            frame_cnt_reg <= frame_cnt_next;
            stuck_reg     <= stuck_next;
            all_reg       <= all_next;
            for (int k = 0; k < ENCODER_COUNT; k++)
            begin
                last_pos_reg[k] <= last_pos_next[k];
                rep_cnt_reg[k]  <= rep_cnt_next[k];
            end
        end
    end

    assign result.encoder_index = IDX_W'(enc);
    assign result.position      = pos;
    assign result.frame_done    = done;
    assign result.stuck_mask    = stuck_next;
    assign result.all_stuck     = all_next;

endmodule

>>> sim/tb_encoder_chain_stuck_detector_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the encoder chain stuck detector
// Feeds chain words through the valid/stall input channel and checks every
// result beat against a cycle-free model of the repeat counters and flags.
// The stuck threshold is rewritten between phases while the block is idle.
// Both channels see random idle and stall gaps.
// ---------------------------------------------------------------------------
import ecsd_pkg::*;

class stuck_scoreboard;
    logic [COUNT_W-1:0]   threshold;
    int                   slot;
    logic [POS_W-1:0]     last_pos [ENCODER_COUNT];
    logic [COUNT_W-1:0]   reps [ENCODER_COUNT];
    bit                   frame_same;
    logic [COUNT_W-1:0]   frame_reps;
    logic [MASK_BITS-1:0] stuck_flags;
    bit                   all_flag;
    ecsd_result_t         pending_results [$];
    int                   errors;

    function new();
        threshold   = THRESHOLD_RESET;
        slot        = 0;
        for (int k = 0; k < ENCODER_COUNT; k++)
        begin
            last_pos[k] = '0;
            reps[k]     = '0;
        end
        frame_same  = 1'b1;
        frame_reps  = '0;
        stuck_flags = '0;
        all_flag    = 1'b0;
        errors      = 0;
    endfunction

    function void note_word(logic [WORD_W-1:0] word);
        ecsd_result_t     r;
        logic [POS_W-1:0] pos;
        int               s;
        int               enc;
        bit               done;
        pos = word[POS_W-1:0];
        s = (slot >= ENCODER_COUNT) ? 0 : slot;
        enc = ENCODER_COUNT - 1 - s;
        if (s == 0)
            frame_same = 1'b1;
        if (pos == last_pos[enc])
        begin
            if (reps[enc] != COUNT_MAX)
                reps[enc] = reps[enc] + 1'b1;
        end
        else
        begin
            reps[enc]  = '0;
            frame_same = 1'b0;
        end
        last_pos[enc] = pos;
        done = (s + 1 >= ENCODER_COUNT);
        if (done)
        begin
            slot = 0;
            if (!frame_same)
                frame_reps = '0;
            else if (frame_reps < threshold)
                frame_reps = frame_reps + 1'b1;
            all_flag    = (frame_reps >= threshold);
            stuck_flags = '0;
            for (int k = 0; k < ENCODER_COUNT && k < MASK_BITS; k++)
                if (reps[k] >= threshold)
                    stuck_flags[k] = 1'b1;
        end
        else
        begin
            slot = s + 1;
        end
        r.encoder_index = IDX_W'(enc);
        r.position      = pos;
        r.frame_done    = done;
        r.stuck_mask    = stuck_flags;
        r.all_stuck     = all_flag;
        pending_results.push_back(r);
    endfunction

    function void fail(string what, int want, int got);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(ecsd_result_t got);
        ecsd_result_t want;
        if (pending_results.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("[%0t] result beat with nothing pending (index %0d, position %0d)",
                         $time, got.encoder_index, got.position);
            return;
        end
        want = pending_results.pop_front();
        if (got.encoder_index !== want.encoder_index)
            fail("encoder_index", want.encoder_index, got.encoder_index);
        if (got.position !== want.position)
            fail("position", want.position, got.position);
        if (got.frame_done !== want.frame_done)
            fail("frame_done", want.frame_done, got.frame_done);
        if (got.stuck_mask !== want.stuck_mask)
            fail("stuck_mask", want.stuck_mask, got.stuck_mask);
        if (got.all_stuck !== want.all_stuck)
            fail("all_stuck", want.all_stuck, got.all_stuck);
    endfunction
endclass

module tb_encoder_chain_stuck_detector_unit;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [WORD_W-1:0]    spi_word;
    logic                 out_valid;
    logic                 out_stall;
    logic [IDX_W-1:0]     encoder_index;
    logic [POS_W-1:0]     position;
    logic                 frame_done;
    logic [MASK_BITS-1:0] stuck_mask;
    logic                 all_stuck;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data;

    stuck_scoreboard      sb;
    bit                   quiet;
    int                   stall_left;
    logic [WORD_W-1:0]    chain_words [ENCODER_COUNT];

    encoder_chain_stuck_detector_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .spi_word      (spi_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .encoder_index (encoder_index),
        .position      (position),
        .frame_done    (frame_done),
        .stuck_mask    (stuck_mask),
        .all_stuck     (all_stuck),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one; none at all in quiet phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        spi_word <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(word);
    endtask

    task automatic write_threshold(input logic [COUNT_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.threshold = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return WORD_W'($urandom_range(0, 65535));
    endfunction

    // Upper two bits are outside the angle, so they change freely on repeats.
    function automatic logic [WORD_W-1:0] reshuffle_top(logic [WORD_W-1:0] word);
        return {2'($urandom_range(0, 3)), word[POS_W-1:0]};
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({encoder_index, position, frame_done, stuck_mask, all_stuck});
    end

    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 3) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    initial
    begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int random_items;
        int phase;
        int frames;
        int r;
        logic [COUNT_W-1:0] thr;
        bit long_run;

        sb        = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        spi_word  = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        quiet     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset threshold: zero frames match the
        // cleared positions, then the angle extremes under varied top bits.
        send_word(16'h0000);
        send_word(16'h0000);
        send_word(16'h0000);
        send_word(16'hffff);
        send_word(16'hc000);
        send_word(16'h3fff);
        send_word(16'h7fff);
        send_word(16'h4000);
        send_word(16'hbfff);
        send_word(16'h2aaa);
        send_word(16'h1555);
        send_word(16'h8001);

        // A zero threshold raises every flag that gets updated.
        write_threshold(8'd0);
        send_word(16'h0123);
        send_word(16'h3210);
        send_word(16'h1111);

        // Threshold one: a single repeat of the frame is enough.
        write_threshold(8'd1);
        for (int n = 0; n < 2; n++)
        begin
            send_word(16'h0a0a);
            send_word(16'h0b0b);
            send_word(16'h0c0c);
        end

        for (int k = 0; k < ENCODER_COUNT; k++)
            chain_words[k] = rand_word();
        random_items = 0;
        phase = 0;
        while (random_items < 1400)
        begin
            long_run = 1'b0;
            unique case (phase)
                0: thr = 8'd2;
                1:
                begin
                    thr = 8'd255;
                    long_run = 1'b1;
                end
                2: thr = 8'd1;
                3: thr = 8'd0;
                4: thr = 8'd3;
                default:
                    thr = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 255))
                                                      : COUNT_W'($urandom_range(1, 8));
            endcase
            write_threshold(thr);
            quiet  = ($urandom_range(0, 3) == 0);
            // The long run holds every angle so the counters hit saturation.
            frames = long_run ? 270 : $urandom_range(10, 40);
            for (int f = 0; f < frames; f++)
            begin
                r = long_run ? 0 : $urandom_range(0, 99);
                if (r >= 97)
                begin
                    // A stray word or two shifts the frame alignment.
                    repeat ($urandom_range(1, 2))
                    begin
                        send_word(rand_word());
                        random_items++;
                    end
                    continue;
                end
                if (r >= 85)
                begin
                    for (int k = 0; k < ENCODER_COUNT; k++)
                        chain_words[k] = rand_word();
                end
                else if (r >= 70)
                begin
                    chain_words[$urandom_range(0, ENCODER_COUNT - 1)] = rand_word();
                end
                for (int k = 0; k < ENCODER_COUNT; k++)
                begin
                    chain_words[k] = reshuffle_top(chain_words[k]);
                    send_word(chain_words[k]);
                    random_items++;
                end
            end
            phase++;
        end
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
